// ===== hdl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CODE_W  = 8;
    localparam int INDEX_W = 11;
    localparam int CELL_W  = 16;

    typedef logic [CELL_W-1:0]  t_cell;
    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [INDEX_W-1:0] t_index;

    localparam t_cell BLANK_CELL   = 16'h0720;
    localparam t_cell ATTR_BITS    = 16'h0700;
    localparam t_code NEWLINE_CODE = 8'h0A;

    typedef enum logic {
        CMD_PUT  = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/tcw_in_if.sv =====
`default_nettype none

interface tcw_in_if;
    import tcw_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   cmd;
    t_code  char_code;
    t_index read_index;

    modport source (output valid, output cmd, output char_code, output read_index,
                    input ready);
    modport sink   (input valid, input cmd, input char_code, input read_index,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/tcw_out_if.sv =====
`default_nettype none

interface tcw_out_if;
    import tcw_pkg::*;

    logic   valid;
    logic   ready;
    t_cell  cell_value;
    t_index cursor_position;
    logic   scrolled;

    modport source (output valid, output cell_value, output cursor_position,
                    output scrolled, input ready);
    modport sink   (input valid, input cell_value, input cursor_position,
                    input scrolled, output ready);
endinterface

`default_nettype wire

// ===== hdl/tcw_screen_store.sv =====
`default_nettype none

module tcw_screen_store #(
    parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire tcw_pkg::t_cell i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output tcw_pkg::t_cell     o_rdata
);
    import tcw_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
// Text console writer for a COLUMNS x ROWS screen store (80x25 by default).
// Input channel i_in carries one word per item: cmd PUT writes char_code at
// the cursor (newline moves to the next row), cmd READ fetches the cell at
// read_index. Output channel o_out returns exactly one word per item: the
// cell (0 for a put or an out-of-range read), the linear cursor position
// and a scroll flag.
// Timing: a plain put's result is registered in the cycle after it is taken; a
// read passes through ST_READ for the store read before its result is registered.
// No new item is taken while the last one is in flight: a put lands its write and
// a read waits on the store in the cycle after accept.
// A put or newline that passes the bottom row scrolls the screen: ST_COPY makes
// one copy per cycle for each cell of the upper rows, then ST_BLANK blanks the
// bottom row, and the put's result is given as ST_BLANK ends.
// Reset: a clearing pass (ST_CLEAR) writes a blank to every cell of the store;
// no item is taken during it. Cursor goes to 0.
// Stall: the result sits in an output register until o_out.ready; while it
// waits, the next item is taken only in the cycle the result is collected.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcw_in_if.sink    i_in,
    tcw_out_if.source o_out
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(COLUMNS);
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;
    localparam int LAST_CELL  = CELL_COUNT - 1;
    localparam int LAST_COPY  = LAST_BASE - 1;
    localparam int LAST_COL   = COLUMNS - 1;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_col, n_col;
    logic [AW-1:0]   r_base, n_base;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_wr_addr, n_wr_addr;
    t_cell           r_wr_data, n_wr_data;
    logic            r_wr_copy, n_wr_copy;
    logic            r_rd_ok, n_rd_ok;
    logic            r_out_valid, n_out_valid;
    t_cell           r_cell, n_cell;
    t_index          r_cur, n_cur;
    logic            r_scr, n_scr;

    logic [AW-1:0]   rd_addr;
    t_cell           rd_data;
    t_cell           wr_data;
    logic            accept;
    logic            step;
    logic            scroll;

    tcw_screen_store #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_pend),
        .i_waddr (r_wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign wr_data = r_wr_copy ? rd_data : r_wr_data;

    assign i_in.ready = (r_state == ST_IDLE) && !r_pend && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    assign o_out.valid           = r_out_valid;
    assign o_out.cell_value      = r_cell;
    assign o_out.cursor_position = r_cur;
    assign o_out.scrolled        = r_scr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_pend      <= 1'b0;
            r_wr_copy   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_col       <= n_col;
            r_base      <= n_base;
            r_pend      <= n_pend;
            r_wr_copy   <= n_wr_copy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_wr_data <= n_wr_data;
        r_rd_ok   <= n_rd_ok;
        r_cell    <= n_cell;
        r_cur     <= n_cur;
        r_scr     <= n_scr;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_col       = r_col;
        n_base      = r_base;
        n_pend      = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_wr_data   = r_wr_data;
        n_wr_copy   = 1'b0;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && !o_out.ready;
        n_cell      = r_cell;
        n_cur       = r_cur;
        n_scr       = r_scr;
        rd_addr     = r_cnt + AW'(COLUMNS);
        step        = 1'b0;
        scroll      = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                n_pend    = 1'b1;
                n_wr_addr = r_cnt;
                n_wr_data = BLANK_CELL;
                if (r_cnt == AW'(LAST_CELL)) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                rd_addr = AW'(i_in.read_index);
                if (accept) begin
                    if (i_in.cmd == CMD_READ) begin
                        n_state = ST_READ;
                        n_rd_ok = 32'(i_in.read_index) < 32'(CELL_COUNT);
                    end else begin
                        // write the character unless it is a newline, then advance the cursor
                        if (i_in.char_code != NEWLINE_CODE) begin
                            n_pend    = 1'b1;
                            n_wr_addr = r_base + AW'(r_col);
                            n_wr_data = ATTR_BITS | CELL_W'(i_in.char_code);
                        end
                        step = (i_in.char_code == NEWLINE_CODE) || (r_col == CW'(LAST_COL));
                        if (step) begin
                            n_col = '0;
                            if (r_base == AW'(LAST_BASE)) begin
                                scroll  = 1'b1;
                                n_state = ST_COPY;
                                n_cnt   = '0;
                            end else begin
                                n_base = r_base + AW'(COLUMNS);
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                        if (!scroll) begin
                            n_out_valid = 1'b1;
                            n_cell      = '0;
                            n_cur       = INDEX_W'(n_base + AW'(n_col));
                            n_scr       = 1'b0;
                        end
                    end
                end
            end
            ST_READ: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_cell      = r_rd_ok ? rd_data : '0;
                n_cur       = INDEX_W'(r_base + AW'(r_col));
                n_scr       = 1'b0;
            end
            ST_COPY: begin
                // move each cell up one row
                n_pend    = 1'b1;
                n_wr_copy = 1'b1;
                n_wr_addr = r_cnt;
                if (r_cnt == AW'(LAST_COPY)) begin
                    n_state = ST_BLANK;
                    n_cnt   = AW'(LAST_BASE);
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_BLANK: begin
                n_pend    = 1'b1;
                n_wr_addr = r_cnt;
                n_wr_data = BLANK_CELL;
                if (r_cnt == AW'(LAST_CELL)) begin
                    n_state     = ST_IDLE;
                    n_cnt       = '0;
                    n_out_valid = 1'b1;
                    n_cell      = '0;
                    n_cur       = INDEX_W'(LAST_BASE);
                    n_scr       = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_base) + 32'(r_col)) < 32'(CELL_COUNT))
        else $error("cursor beyond screen");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_scr |-> r_cur == INDEX_W'(LAST_BASE))
        else $error("scroll result not on bottom row");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.cmd == CMD_READ |=> !r_out_valid && r_state == ST_READ ##1 r_out_valid)
        else $error("read result late");

    a_put_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.cmd == CMD_PUT && r_state == ST_IDLE && n_state == ST_IDLE
        |=> r_out_valid && !r_scr)
        else $error("put result missing");

    a_copy_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_COPY || r_state == ST_BLANK |=> r_pend)
        else $error("store write dropped");
`endif

endmodule

`default_nettype wire
